// ----- hdl/ljp_pkg.sv -----
// ljp_pkg: shared types, codes, constants and saturating helpers for the
// Lennard-Jones pair force engine. No dependencies.
`default_nettype none
package ljp_pkg;

  localparam int MAX_PARTICLES_DEF = 2048;
  localparam int IDX_W      = 11;
  localparam int CNT_W      = 12;
  localparam int POS_W      = 32;
  localparam int FRC_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int R2_W       = 50;   // sum of three (d*d)>>16 terms
  localparam int QUO_W      = 49;   // floor(2^48 / r2)

  localparam logic [CNT_W-1:0]      PCOUNT_RST = 12'd2048;
  localparam logic [CFG_DATA_W-1:0] WDEPTH_RST = 32'd65536;
  localparam logic [CFG_DATA_W-1:0] MINDSQ_RST = 32'd7;

  localparam logic [FRC_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [FRC_W-1:0] POSMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCOUNT = 2'd0,
    CFG_WDEPTH = 2'd1,
    CFG_MINDSQ = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [FRC_W-1:0] x;
    logic [FRC_W-1:0] y;
    logic [FRC_W-1:0] z;
  } fvec_t;

  // product scaling of the shared multiplier
  typedef enum logic [1:0] {
    SH0  = 2'd0,
    SH16 = 2'd1,
    SH32 = 2'd2
  } shift_t;

  // micro-op sequence of one pair
  typedef enum logic [3:0] {
    OP_SQ0, OP_SQ1, OP_SQ2,
    OP_T, OP_R6, OP_R12,
    OP_EW, OP_E4,
    OP_T2, OP_FW, OP_F24, OP_S,
    OP_F0, OP_F1, OP_F2
  } pop_t;

  typedef enum logic [2:0] {
    P_IDLE, P_MST, P_MWT, P_CHK, P_DIV, P_FIN
  } pst_t;

  typedef enum logic [3:0] {
    T_CLR, T_IDLE, T_I_CHK, T_I_LAT, T_J_RD, T_J_LAT,
    T_PAIR, T_F_MOD, T_I_WR, T_FIN
  } tst_t;

  typedef struct packed {
    logic             skip;
    logic             sat;
    logic [FRC_W-1:0] e;
    fvec_t            f;
  } pair_res_t;

  // {saturated, value}
  function automatic logic [FRC_W:0] make_signed_f(input logic neg,
                                                   input logic [FRC_W-1:0] mag);
    logic [FRC_W:0] r;
    if (neg) begin
      if (mag > SIGN64) r = {1'b1, SIGN64};
      else              r = {1'b0, (~mag) + 64'd1};
    end else begin
      if (mag > POSMAX) r = {1'b1, POSMAX};
      else              r = {1'b0, mag};
    end
    return r;
  endfunction

  function automatic logic [FRC_W:0] sat_add_f(input logic [FRC_W-1:0] a,
                                               input logic [FRC_W-1:0] b);
    logic [FRC_W-1:0] s;
    logic [FRC_W:0]   r;
    s = a + b;
    if ((a[FRC_W-1] == b[FRC_W-1]) && (s[FRC_W-1] != a[FRC_W-1]))
      r = {1'b1, a[FRC_W-1] ? SIGN64 : POSMAX};
    else
      r = {1'b0, s};
    return r;
  endfunction

  function automatic logic [FRC_W:0] sat_sub_f(input logic [FRC_W-1:0] a,
                                               input logic [FRC_W-1:0] b);
    logic [FRC_W-1:0] s;
    logic [FRC_W:0]   r;
    s = a - b;
    if ((a[FRC_W-1] != b[FRC_W-1]) && (s[FRC_W-1] != a[FRC_W-1]))
      r = {1'b1, a[FRC_W-1] ? SIGN64 : POSMAX};
    else
      r = {1'b0, s};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lennard_jones_pair_forces.sv -----
// lennard_jones_pair_forces: top level. Position and force memories, run
// sequencer over all pairs, command and result channels. Uses ljp_pkg,
// ljp_ram and ljp_pair.
//
//   channel | ports                              | beat moves
//   --------+------------------------------------+------------------------------
//   in      | in_valid/in_ready, in_mode..in_pos_z | write position, run, read force
//   out     | out_valid/out_ready, out_force_*.. | forces, energy, saturated
//   cfg     | cfg_valid/cfg_ready, cfg_index/data | particle_count, well_depth,
//           |                                    | min_dist_sq
//
// After reset, and at the start of every run, the force memory is cleared
// one entry per cycle; no input beat is taken during the reset clearing pass.
// A run then works through every pair with the shared multiplier (per product:
// issue, four partial products, accumulate, scale and handshake) and, for a
// pair that is not skipped, the 49-step divider, plus a position read and a
// force write-back per particle. A finished result waits in the output
// register; the next beat is accepted while it waits and is held at its end
// until the register frees.
`default_nettype none
module lennard_jones_pair_forces #(
  parameter int MAX_PARTICLES = ljp_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [1:0]                       in_mode,
  input  wire logic [ljp_pkg::IDX_W-1:0]        in_index,
  input  wire logic signed [ljp_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [ljp_pkg::POS_W-1:0] in_pos_y,
  input  wire logic signed [ljp_pkg::POS_W-1:0] in_pos_z,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic signed [ljp_pkg::FRC_W-1:0] out_force_x,
  output      logic signed [ljp_pkg::FRC_W-1:0] out_force_y,
  output      logic signed [ljp_pkg::FRC_W-1:0] out_force_z,
  output      logic signed [ljp_pkg::FRC_W-1:0] out_energy,
  output      logic                             out_saturated,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [ljp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ljp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ljp_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PARTICLES - 1);

  tst_t st_r, st_nxt;

  // configuration
  logic [CNT_W-1:0]      pcount_r;
  logic [CFG_DATA_W-1:0] wdepth_r, mindsq_r;

  // run control
  logic [CW-1:0] n_r, i_r, j_r;
  logic [AW-1:0] clr_r;
  logic          run_r;
  pos_t          pi_r;
  fvec_t         acc_r;
  logic [63:0]   energy_r;
  logic          flag_r;
  mode_t         mode_r;
  logic          rng_r;

  // output register
  logic        out_valid_r;
  fvec_t       out_f_r;
  logic [63:0] out_e_r;
  logic        out_s_r;

  // memories
  logic          pos_we, pos_re, frc_we, frc_re;
  logic [AW-1:0] pos_waddr, pos_raddr, frc_waddr, frc_raddr;
  pos_t          pos_wdata, pos_q;
  fvec_t         frc_wdata, frc_q;

  // pair unit
  logic      pair_start, pair_done;
  pair_res_t pres;

  logic        in_fire, in_rng, out_free, j_end;
  mode_t       in_md;
  logic [CW-1:0] n_cfg;
  logic [64:0] ea, ax, ay, az, sx, sy, sz, wx, wy, wz;

  ljp_ram #(.WIDTH($bits(pos_t)), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_q)
  );

  ljp_ram #(.WIDTH($bits(fvec_t)), .DEPTH(MAX_PARTICLES)) u_frc_ram (
    .clk   (clk),
    .we    (frc_we),
    .waddr (frc_waddr),
    .wdata (frc_wdata),
    .re    (frc_re),
    .raddr (frc_raddr),
    .rdata (frc_q)
  );

  ljp_pair u_pair (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (pair_start),
    .pi          (pi_r),
    .pj          (pos_q),
    .well_depth  (wdepth_r),
    .min_dist_sq (mindsq_r),
    .done        (pair_done),
    .res         (pres)
  );

  assign in_ready  = (st_r == T_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_md     = mode_t'(in_mode);
  assign in_rng    = (32'(in_index) < MAX_PARTICLES);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign j_end     = (j_r >= n_r);
  assign n_cfg     = (32'(pcount_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(pcount_r);

  // saturating updates
  assign ea = sat_add_f(energy_r, pres.e);
  assign ax = sat_add_f(acc_r.x, pres.f.x);
  assign ay = sat_add_f(acc_r.y, pres.f.y);
  assign az = sat_add_f(acc_r.z, pres.f.z);
  assign sx = sat_sub_f(frc_q.x, pres.f.x);
  assign sy = sat_sub_f(frc_q.y, pres.f.y);
  assign sz = sat_sub_f(frc_q.z, pres.f.z);
  assign wx = sat_add_f(frc_q.x, acc_r.x);
  assign wy = sat_add_f(frc_q.y, acc_r.y);
  assign wz = sat_add_f(frc_q.z, acc_r.z);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_CLR:   if (clr_r == LAST_ADDR) st_nxt = run_r ? T_I_CHK : T_IDLE;
      T_IDLE: begin
        if (in_fire) st_nxt = (in_md == MODE_RUN) ? T_CLR : T_FIN;
      end
      T_I_CHK: st_nxt = ((i_r + CW'(1)) >= n_r) ? T_FIN : T_I_LAT;
      T_I_LAT: st_nxt = T_J_RD;
      T_J_RD:  st_nxt = j_end ? T_I_WR : T_J_LAT;
      T_J_LAT: st_nxt = T_PAIR;
      T_PAIR:  if (pair_done) st_nxt = pres.skip ? T_J_RD : T_F_MOD;
      T_F_MOD: st_nxt = T_J_RD;
      T_I_WR:  st_nxt = T_I_CHK;
      T_FIN:   if (out_free) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // memory and pair controls
  always_comb begin
    pos_we     = 1'b0;
    pos_waddr  = AW'(in_index);
    pos_wdata  = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
    pos_re     = 1'b0;
    pos_raddr  = AW'(i_r);
    frc_we     = 1'b0;
    frc_waddr  = clr_r;
    frc_wdata  = '0;
    frc_re     = 1'b0;
    frc_raddr  = AW'(in_index);
    pair_start = 1'b0;
    unique case (st_r)
      T_CLR: frc_we = 1'b1;
      T_IDLE: begin
        pos_we = in_fire && (in_md == MODE_WRITE) && in_rng;
        frc_re = in_fire && (in_md == MODE_READ);
      end
      T_I_CHK: pos_re = 1'b1;
      T_J_RD: begin
        pos_re    = !j_end;
        pos_raddr = AW'(j_r);
        frc_re    = j_end;
        frc_raddr = AW'(i_r);
      end
      T_J_LAT: pair_start = 1'b1;
      T_PAIR: begin
        frc_re    = pair_done && !pres.skip;
        frc_raddr = AW'(j_r);
      end
      T_F_MOD: begin
        frc_we    = 1'b1;
        frc_waddr = AW'(j_r);
        frc_wdata = '{x: sx[63:0], y: sy[63:0], z: sz[63:0]};
      end
      T_I_WR: begin
        frc_we    = 1'b1;
        frc_waddr = AW'(i_r);
        frc_wdata = '{x: wx[63:0], y: wy[63:0], z: wz[63:0]};
      end
      default: ;
    endcase
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= T_CLR;
      clr_r    <= '0;
      run_r    <= 1'b0;
      pcount_r <= PCOUNT_RST;
      wdepth_r <= WDEPTH_RST;
      mindsq_r <= MINDSQ_RST;
      energy_r <= '0;
      flag_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PCOUNT: pcount_r <= cfg_data[CNT_W-1:0];
          CFG_WDEPTH: wdepth_r <= cfg_data;
          CFG_MINDSQ: mindsq_r <= cfg_data;
          default: ;
        endcase
      end
      // a beat leaving while the next one loads is covered in T_FIN
      if (out_valid_r && out_ready && (st_r != T_FIN)) out_valid_r <= 1'b0;
      unique case (st_r)
        T_CLR: clr_r <= clr_r + AW'(1);
        T_IDLE: begin
          if (in_fire) begin
            mode_r <= in_md;
            rng_r  <= in_rng;
            if (in_md == MODE_RUN) begin
              run_r    <= 1'b1;
              clr_r    <= '0;
              energy_r <= '0;
              flag_r   <= 1'b0;
              n_r      <= n_cfg;
              i_r      <= '0;
            end
          end
        end
        T_I_LAT: begin
          pi_r  <= pos_q;
          acc_r <= '0;
          j_r   <= i_r + CW'(1);
        end
        T_PAIR: begin
          if (pair_done) begin
            if (pres.skip) begin
              j_r <= j_r + CW'(1);
            end else begin
              energy_r <= ea[63:0];
              acc_r    <= '{x: ax[63:0], y: ay[63:0], z: az[63:0]};
              flag_r   <= flag_r | pres.sat | ea[64] | ax[64] | ay[64] | az[64];
            end
          end
        end
        T_F_MOD: begin
          flag_r <= flag_r | sx[64] | sy[64] | sz[64];
          j_r    <= j_r + CW'(1);
        end
        T_I_WR: begin
          flag_r <= flag_r | wx[64] | wy[64] | wz[64];
          i_r    <= i_r + CW'(1);
        end
        T_FIN: begin
          if (out_free) begin
            run_r       <= 1'b0;
            out_valid_r <= 1'b1;
            out_f_r     <= ((mode_r == MODE_READ) && rng_r) ? frc_q : '0;
            out_e_r     <= energy_r;
            out_s_r     <= flag_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_force_x   = out_f_r.x;
  assign out_force_y   = out_f_r.y;
  assign out_force_z   = out_f_r.z;
  assign out_energy    = out_e_r;
  assign out_saturated = out_s_r;

endmodule
`default_nettype wire

// ----- hdl/ljp_ram.sv -----
// ljp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ljp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/ljp_mul.sv -----
// ljp_mul: shared 64x64 multiplier, one 32x32 partial product per cycle,
// scaled by 2^0, 2^-16 or 2^-32 with saturation. Depends on ljp_pkg.
`default_nettype none
module ljp_mul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [63:0]         a,
  input  wire logic [63:0]         b,
  input  wire ljp_pkg::shift_t     sh,
  output      logic                done,
  output      logic [63:0]         res,
  output      logic                sat
);
  import ljp_pkg::*;

  localparam logic [2:0] PARTS   = 3'd4;
  localparam logic [2:0] LAST_CT = 3'd5;

  logic [63:0]  a_r, b_r, prod_r, res_r;
  logic [127:0] acc_r, addend;
  logic [63:0]  pp, hi, res_c;
  logic         sat_c;
  shift_t       sh_r;
  logic [2:0]   cnt_r, prev;
  logic         busy_r, done_r, sat_r;

  // partial product for the current slot
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: pp = a_r[31:0]  * b_r[31:0];
      2'd1: pp = a_r[31:0]  * b_r[63:32];
      2'd2: pp = a_r[63:32] * b_r[31:0];
      2'd3: pp = a_r[63:32] * b_r[63:32];
      default: pp = '0;
    endcase
  end

  // alignment of the previous partial product
  assign prev = cnt_r - 3'd1;
  always_comb begin
    unique case (prev[1:0])
      2'd0: addend = {64'd0, prod_r};
      2'd1, 2'd2: addend = {32'd0, prod_r, 32'd0};
      2'd3: addend = {prod_r, 64'd0};
      default: addend = '0;
    endcase
  end

  // scaling and saturation
  assign hi = acc_r[127:64];
  always_comb begin
    unique case (sh_r)
      SH16: begin
        sat_c = |hi[63:16];
        res_c = acc_r[79:16];
      end
      SH32: begin
        sat_c = |hi[63:32];
        res_c = acc_r[95:32];
      end
      default: begin
        sat_c = |hi;
        res_c = acc_r[63:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      a_r    <= a;
      b_r    <= b;
      sh_r   <= sh;
      acc_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r < PARTS) begin
        prod_r <= pp;
      end
      if ((cnt_r != 3'd0) && (cnt_r <= PARTS)) begin
        acc_r <= acc_r + addend;
      end
      if (cnt_r == LAST_CT) begin
        res_r  <= sat_c ? '1 : res_c;
        sat_r  <= sat_c;
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule
`default_nettype wire

// ----- hdl/ljp_pair.sv -----
// ljp_pair: sequencer for one particle pair: distance, skip test, bit-serial
// 1/r2 divider and the multiply chain for energy and force. Uses ljp_mul, ljp_pkg.
`default_nettype none
module ljp_pair (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire ljp_pkg::pos_t       pi,
  input  wire ljp_pkg::pos_t       pj,
  input  wire logic [31:0]         well_depth,
  input  wire logic [31:0]         min_dist_sq,
  output      logic                done,
  output      ljp_pkg::pair_res_t  res
);
  import ljp_pkg::*;

  localparam logic [5:0] DIV_TOP = 6'(QUO_W - 1);

  pst_t st_r, st_nxt;
  pop_t op_r;

  logic [31:0]      ad_r [3];
  logic [2:0]       dneg_r;
  logic [R2_W-1:0]  r2_r, rem_r;
  logic [R2_W:0]    rem_s;
  logic [QUO_W-1:0] q_r;
  logic [5:0]       dcnt_r;
  logic [63:0]      t_r, r6_r, r12_r, m_r, s_r, e_r;
  logic [63:0]      f_r [3];
  logic             neg_e_r, neg_f_r, sat_r, skip_r;

  logic             mul_start, mul_done, mul_sat;
  logic [63:0]      mul_a, mul_b, mul_res;
  shift_t           mul_sh;
  logic [64:0]      ms;
  logic [32:0]      dx, dy, dz;
  logic             is_skip;

  ljp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  // per-axis differences at start
  assign dx = {pi.x[31], pi.x} - {pj.x[31], pj.x};
  assign dy = {pi.y[31], pi.y} - {pj.y[31], pj.y};
  assign dz = {pi.z[31], pi.z} - {pj.z[31], pj.z};

  assign is_skip = (r2_r == '0) || (r2_r < R2_W'(min_dist_sq));
  assign rem_s   = {rem_r, (dcnt_r == DIV_TOP)};

  // operand select per micro-op
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH0;
    unique case (op_r)
      OP_SQ0: begin mul_a = 64'(ad_r[0]); mul_b = 64'(ad_r[0]); mul_sh = SH16; end
      OP_SQ1: begin mul_a = 64'(ad_r[1]); mul_b = 64'(ad_r[1]); mul_sh = SH16; end
      OP_SQ2: begin mul_a = 64'(ad_r[2]); mul_b = 64'(ad_r[2]); mul_sh = SH16; end
      OP_T:   begin mul_a = 64'(q_r); mul_b = 64'(q_r); mul_sh = SH32; end
      OP_R6:  begin mul_a = t_r;  mul_b = 64'(q_r); mul_sh = SH32; end
      OP_R12: begin mul_a = r6_r; mul_b = r6_r;     mul_sh = SH32; end
      OP_EW: begin
        mul_a  = (r12_r < r6_r) ? (r6_r - r12_r) : (r12_r - r6_r);
        mul_b  = 64'(well_depth);
        mul_sh = SH16;
      end
      OP_E4:  begin mul_a = m_r;   mul_b = 64'd4; mul_sh = SH0; end
      OP_T2:  begin mul_a = r12_r; mul_b = 64'd2; mul_sh = SH0; end
      OP_FW: begin
        mul_a  = (t_r < r6_r) ? (r6_r - t_r) : (t_r - r6_r);
        mul_b  = 64'(well_depth);
        mul_sh = SH16;
      end
      OP_F24: begin mul_a = m_r; mul_b = 64'd24;     mul_sh = SH0;  end
      OP_S:   begin mul_a = m_r; mul_b = 64'(q_r);   mul_sh = SH32; end
      OP_F0:  begin mul_a = s_r; mul_b = 64'(ad_r[0]); mul_sh = SH16; end
      OP_F1:  begin mul_a = s_r; mul_b = 64'(ad_r[1]); mul_sh = SH16; end
      OP_F2:  begin mul_a = s_r; mul_b = 64'(ad_r[2]); mul_sh = SH16; end
      default: ;
    endcase
  end

  // signed result of the energy or force term being written back
  always_comb begin
    unique case (op_r)
      OP_E4:   ms = make_signed_f(neg_e_r, mul_res);
      OP_F0:   ms = make_signed_f(neg_f_r ^ dneg_r[0], mul_res);
      OP_F1:   ms = make_signed_f(neg_f_r ^ dneg_r[1], mul_res);
      OP_F2:   ms = make_signed_f(neg_f_r ^ dneg_r[2], mul_res);
      default: ms = {1'b0, mul_res};
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      P_IDLE: if (start) st_nxt = P_MST;
      P_MST:  st_nxt = P_MWT;
      P_MWT: begin
        if (mul_done) begin
          if (op_r == OP_SQ2)     st_nxt = P_CHK;
          else if (op_r == OP_F2) st_nxt = P_FIN;
          else                    st_nxt = P_MST;
        end
      end
      P_CHK:  st_nxt = is_skip ? P_FIN : P_DIV;
      P_DIV:  if (dcnt_r == '0) st_nxt = P_MST;
      P_FIN:  st_nxt = P_IDLE;
      default: st_nxt = P_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mul_start = (st_r == P_MST);
    done      = (st_r == P_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      P_IDLE: begin
        if (start) begin
          ad_r[0] <= dx[32] ? 32'(-dx) : dx[31:0];
          ad_r[1] <= dy[32] ? 32'(-dy) : dy[31:0];
          ad_r[2] <= dz[32] ? 32'(-dz) : dz[31:0];
          dneg_r  <= {dz[32], dy[32], dx[32]};
          r2_r    <= '0;
          op_r    <= OP_SQ0;
          sat_r   <= 1'b0;
          skip_r  <= 1'b0;
        end
      end
      P_MST: begin
        if (op_r == OP_EW) neg_e_r <= (r12_r < r6_r);
        if (op_r == OP_FW) neg_f_r <= (t_r < r6_r);
      end
      P_MWT: begin
        if (mul_done) begin
          sat_r <= sat_r | mul_sat | ms[64];
          unique case (op_r)
            OP_SQ0, OP_SQ1, OP_SQ2: r2_r <= r2_r + mul_res[R2_W-1:0];
            OP_T, OP_T2:            t_r  <= mul_res;
            OP_R6:                  r6_r <= mul_res;
            OP_R12:                 r12_r <= mul_res;
            OP_EW, OP_FW, OP_F24:   m_r  <= mul_res;
            OP_E4:                  e_r  <= ms[63:0];
            OP_S:                   s_r  <= mul_res;
            OP_F0:                  f_r[0] <= ms[63:0];
            OP_F1:                  f_r[1] <= ms[63:0];
            OP_F2:                  f_r[2] <= ms[63:0];
            default: ;
          endcase
          if (op_r != OP_F2) op_r <= pop_t'(op_r + 4'd1);
        end
      end
      P_CHK: begin
        skip_r <= is_skip;
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= DIV_TOP;
      end
      P_DIV: begin
        // one quotient bit of 2^48 / r2 per cycle
        if (rem_s >= {1'b0, r2_r}) begin
          rem_r <= R2_W'(rem_s - {1'b0, r2_r});
          q_r   <= {q_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_s[R2_W-1:0];
          q_r   <= {q_r[QUO_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 6'd1;
      end
      default: ;
    endcase
  end

  assign res.skip = skip_r;
  assign res.sat  = sat_r;
  assign res.e    = e_r;
  assign res.f.x  = f_r[0];
  assign res.f.y  = f_r[1];
  assign res.f.z  = f_r[2];

endmodule
`default_nettype wire

// ----- dv/tb_lennard_jones_pair_forces.sv -----
// Testbench for lennard_jones_pair_forces: position loads, pair runs and force
// reads, each checked beat by beat against an in-bench fixed-point predictor.
// Depends on ljp_pkg and the lennard_jones_pair_forces RTL.
`timescale 1ns / 100ps

module tb_lennard_jones_pair_forces;
  import ljp_pkg::*;

  localparam int NPART = 2048;

  typedef struct packed {
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] fz;
    logic [63:0] energy;
    logic        sat;
  } beat_res_t;

  typedef struct {
    mode_t       mode;
    logic [10:0] index;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;   // expected result given in the row: all zero
  } cmd_row_t;

  logic        clk, rst_n;
  logic        in_valid, out_ready, cfg_valid;
  logic        in_ready, out_valid, cfg_ready;
  logic [1:0]  in_mode;
  logic [10:0] in_index;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [63:0] out_force_x, out_force_y, out_force_z, out_energy;
  logic        out_saturated;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;

  lennard_jones_pair_forces uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_index(in_index), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_force_x(out_force_x), .out_force_y(out_force_y),
    .out_force_z(out_force_z), .out_energy(out_energy),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] pos_mem [0:NPART-1][0:2];
  logic [63:0]        force_mem [0:NPART-1][0:2];
  logic [63:0]        energy_acc;
  bit                 sat_seen;
  logic [11:0]        n_particles;
  logic [31:0]        epsilon_q;
  logic [31:0]        skip_r2;

  beat_res_t expected_beats[$];
  int errors, beats_seen, runs_sent, burst_mode;

  // ---------------- fixed-point predictor ----------------
  function automatic logic [63:0] mul_scaled(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if ((p >> (64 + sh)) != 0) begin
      sat_seen = 1;
      return '1;
    end
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] mul_small(logic [63:0] a, logic [63:0] k);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, k};
    if (p[127:64] != 0) begin
      sat_seen = 1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] to_signed(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000_0000_0000) begin
        sat_seen = 1;
        return 64'h8000_0000_0000_0000;
      end
      return -mag;
    end
    if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
      sat_seen = 1;
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return mag;
  endfunction

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b, bit sub);
    logic [63:0] bb, s;
    bb = sub ? -b : b;
    s = a + bb;
    // overflow when operand signs agree (for sub: differ) and result flips
    if (((sub ? (a[63] != b[63]) : (a[63] == b[63]))) && (s[63] != a[63])) begin
      sat_seen = 1;
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic void run_all_pairs();
    int n;
    longint d [3];
    logic [63:0] ad [3];
    logic [63:0] acc [3];
    logic [63:0] r2, q, r6, r12, t, mag, s, f;
    bit neg;
    n = (n_particles > NPART) ? NPART : n_particles;
    foreach (force_mem[a, b]) force_mem[a][b] = '0;
    energy_acc = '0;
    sat_seen = 0;
    for (int i = 0; i < n; i++) begin
      acc = '{64'd0, 64'd0, 64'd0};
      for (int j = i + 1; j < n; j++) begin
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
          d[k] = longint'(pos_mem[i][k]) - longint'(pos_mem[j][k]);
          ad[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
          r2 += (ad[k] * ad[k]) >> 16;
        end
        if (r2 == 0 || r2 < {32'd0, skip_r2}) continue;
        q = (64'd1 << 48) / r2;
        r6 = mul_scaled(mul_scaled(q, q, 32), q, 32);
        r12 = mul_scaled(r6, r6, 32);
        // potential energy term
        neg = r12 < r6;
        mag = neg ? r6 - r12 : r12 - r6;
        mag = mul_small(mul_scaled(mag, {32'd0, epsilon_q}, 16), 4);
        energy_acc = clamp_add(energy_acc, to_signed(neg, mag), 0);
        // force scalar over r
        t = mul_small(r12, 2);
        neg = t < r6;
        mag = neg ? r6 - t : t - r6;
        s = mul_scaled(mul_small(mul_scaled(mag, {32'd0, epsilon_q}, 16), 24), q, 32);
        for (int k = 0; k < 3; k++) begin
          f = to_signed(neg != (d[k] < 0), mul_scaled(s, ad[k], 16));
          acc[k] = clamp_add(acc[k], f, 0);
          force_mem[j][k] = clamp_add(force_mem[j][k], f, 1);
        end
      end
      for (int k = 0; k < 3; k++) force_mem[i][k] = clamp_add(force_mem[i][k], acc[k], 0);
    end
  endfunction

  function automatic beat_res_t apply_cmd(mode_t m, logic [10:0] idx,
                                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    beat_res_t r;
    r = '0;
    case (m)
      MODE_WRITE: begin
        pos_mem[idx][0] = x;
        pos_mem[idx][1] = y;
        pos_mem[idx][2] = z;
      end
      MODE_RUN: begin
        run_all_pairs();
        runs_sent++;
      end
      MODE_READ: begin
        r.fx = force_mem[idx][0];
        r.fy = force_mem[idx][1];
        r.fz = force_mem[idx][2];
      end
      default: ;
    endcase
    r.energy = energy_acc;
    r.sat = sat_seen;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_cmd(mode_t m, logic [10:0] idx, logic [31:0] x,
                          logic [31:0] y, logic [31:0] z, bit typed);
    beat_res_t r;
    int gap;
    in_valid <= 1;
    in_mode <= m;
    in_index <= idx;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    do @(posedge clk); while (!in_ready);
    r = apply_cmd(m, idx, x, y, z);
    if (typed) r = '0;
    expected_beats.push_back(r);
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PCOUNT: n_particles = val[11:0];
      CFG_WDEPTH: epsilon_q = val;
      CFG_MINDSQ: skip_r2 = val;
      default: ;
    endcase
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic wait_drained();
    in_valid <= 0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [11:0] cnt, logic [31:0] eps, logic [31:0] mind);
    wait_drained();
    write_reg(CFG_PCOUNT, {20'd0, cnt});
    write_reg(CFG_WDEPTH, eps);
    write_reg(CFG_MINDSQ, mind);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 32'($urandom_range(0, 32'h40000)) - 32'h20000;  // within +/-2.0
    if (sel < 9) return $urandom;
    return 32'h0;
  endfunction

  // ---------------- result checker ----------------
  task automatic check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    beat_res_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        e = expected_beats.pop_front();
        check_field("force_x", e.fx, out_force_x);
        check_field("force_y", e.fy, out_force_y);
        check_field("force_z", e.fz, out_force_z);
        check_field("energy", e.energy, out_energy);
        check_field("saturated", {63'd0, e.sat}, {63'd0, out_saturated});
      end
    end
  end

  // result-side backpressure
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (out_valid && out_ready) stall_left = burst_mode ? 0 : $urandom_range(0, 15);
    end
  end

  // ---------------- directed table ----------------
  cmd_row_t directed [] = '{
    '{MODE_READ,  11'd0,    32'h0,        32'h0,        32'h0,        1},  // reset state
    '{MODE_NONE,  11'd5,    32'hFFFF_FFFF, 32'h1234,    32'h0,        1},  // unused mode
    '{MODE_WRITE, 11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_WRITE, 11'd1,    32'h0001_0000, 32'h0,       32'h0,        0},
    '{MODE_WRITE, 11'd2,    32'h0,        32'h0001_0000, 32'h0,       0},
    '{MODE_WRITE, 11'd3,    32'h0,        32'h0,        32'h0,        0},  // coincident with 0
    '{MODE_RUN,   11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd1,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd2,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd3,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd2047, 32'h0,        32'h0,        32'h0,        0},  // beyond count
    '{MODE_WRITE, 11'd2047, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0},
    '{MODE_WRITE, 11'd1,    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0},
    '{MODE_WRITE, 11'd2,    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0},
    '{MODE_WRITE, 11'd3,    32'h0000_0400, 32'h0,       32'h0,        0},  // very close: saturates
    '{MODE_RUN,   11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd1,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd3,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_WRITE, 11'd3,    32'h0000_0100, 32'h0,       32'h0,        0},  // below skip threshold
    '{MODE_WRITE, 11'd2047, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0},
    '{MODE_RUN,   11'd0,    32'h0,        32'h0,        32'h0,        0},
    '{MODE_READ,  11'd3,    32'h0,        32'h0,        32'h0,        0}
  };

  // register settings per random phase: count, epsilon, skip threshold
  logic [11:0] ph_cnt [8] = '{12'd2, 12'd0, 12'd1, 12'd4, 12'd4, 12'd3, 12'd5, 12'd3};
  logic [31:0] ph_eps [8] = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0,
                              32'hFFFF_FFFF, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000};
  logic [31:0] ph_min [8] = '{32'd7, 32'd7, 32'd7, 32'd0, 32'd7, 32'hFFFF_FFFF,
                              32'h0001_0000, 32'd0};

  initial begin
    int sel, cnt;
    logic [10:0] idx;
    clk = 0;
    rst_n <= 0;
    in_valid <= 0;
    in_mode <= MODE_WRITE;
    in_index <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    cfg_valid <= 0;
    cfg_index <= CFG_PCOUNT;
    cfg_data <= '0;
    errors = 0;
    beats_seen = 0;
    runs_sent = 0;
    burst_mode = 0;
    foreach (pos_mem[a, b]) pos_mem[a][b] = '0;
    foreach (force_mem[a, b]) force_mem[a][b] = '0;
    energy_acc = '0;
    sat_seen = 0;
    n_particles = 12'd2048;
    epsilon_q = 32'd65536;
    skip_r2 = 32'd7;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_regs(12'd4, 32'h0001_0000, 32'd7);
    foreach (directed[r])
      send_cmd(directed[r].mode, directed[r].index, directed[r].px, directed[r].py,
               directed[r].pz, directed[r].typed);

    // random phases: load every particle of the run, then mixed traffic
    for (int p = 0; p < 8; p++) begin
      set_regs(ph_cnt[p], ph_eps[p], ph_min[p]);
      burst_mode = (p % 3 == 1);
      cnt = (ph_cnt[p] < 2) ? 2 : ph_cnt[p];
      for (int i = 0; i < cnt; i++)
        send_cmd(MODE_WRITE, 11'(i), rand_coord(), rand_coord(), rand_coord(), 0);
      for (int it = 0; it < 3; it++) begin
        sel = $urandom_range(0, 99);
        idx = (sel % 2) ? 11'($urandom_range(0, cnt - 1)) : 11'($urandom_range(0, 2047));
        if (sel < 35)
          send_cmd(MODE_WRITE, idx, rand_coord(), rand_coord(), rand_coord(), 0);
        else if (sel < 47)
          send_cmd(MODE_RUN, idx, $urandom, $urandom, $urandom, 0);
        else if (sel < 92)
          send_cmd(MODE_READ, idx, $urandom, $urandom, $urandom, 0);
        else
          send_cmd(MODE_NONE, idx, $urandom, $urandom, $urandom, 0);
      end
      send_cmd(MODE_RUN, '0, '0, '0, '0, 0);
      for (int i = 0; i < cnt; i++)
        send_cmd(MODE_READ, 11'(i), '0, '0, '0, 0);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Summary: %0d result beats checked over %0d runs and 9 register settings.",
             beats_seen, runs_sent);
    $display("Covered loads, runs, force reads, the unused mode and saturating pairs.");
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", expected_beats.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
